### rtl/core/assert_macros.svh
// Assertion macros shared by the im2col address generator RTL.
// Expects i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/im2c_pkg.sv
// Types and constants of the im2col address generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package im2c_pkg;

    localparam int IDX_W     = 32;
    localparam int SIZE_W    = 10;
    localparam int CH_W      = 10;
    localparam int NIB_W     = 4;
    localparam int POS_W     = 12;
    localparam int CNT_W     = 40;
    localparam int DIV_CNT_W = $clog2(SIZE_W + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_LAYOUT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BATCH    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PADDING  = 3'd7;

    localparam logic LAYOUT_NCHW = 1'b0;

    typedef struct packed {
        logic        layout_mode;
        logic [3:0]  batch_count;
        logic [9:0]  channel_count;
        logic [8:0]  image_height;
        logic [8:0]  image_width;
        logic [7:0]  kernel_shape;
        logic [7:0]  stride_shape;
        logic [15:0] padding_shape;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        layout_mode:   1'b0,
        batch_count:   4'd1,
        channel_count: 10'd1,
        image_height:  9'd1,
        image_width:   9'd1,
        kernel_shape:  8'h33,
        stride_shape:  8'h11,
        padding_shape: 16'h0000
    };

    typedef struct packed {
        logic valid;
        logic restart;
    } t_item;

    typedef struct packed {
        logic             valid_res;
        logic [IDX_W-1:0] dest_index;
        logic [IDX_W-1:0] source_index;
        logic             is_padding;
        logic             last_element;
        logic             range_error;
    } t_res;

endpackage

`default_nettype wire

### rtl/core/im2c_regs.sv
// APB configuration registers of the im2col address generator.
// Depends on im2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module im2c_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [im2c_pkg::APB_AW-1:0]  paddr,
    input  logic [im2c_pkg::APB_DW-1:0]  pwdata,
    output logic [im2c_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output im2c_pkg::t_cfg               o_cfg,
    output logic                         o_cfg_wr
);

    im2c_pkg::t_cfg                      r_cfg;
    im2c_pkg::t_cfg                      n_cfg;
    logic                                wr;
    logic [im2c_pkg::REG_IDX_W-1:0]      idx;

    assign pready   = 1'b1;
    assign wr       = psel & penable & pwrite;
    assign idx      = paddr[im2c_pkg::APB_AW-1:2];
    assign o_cfg    = r_cfg;
    assign o_cfg_wr = wr;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            case (idx)
                im2c_pkg::REG_LAYOUT:   n_cfg.layout_mode   = pwdata[0];
                im2c_pkg::REG_BATCH:    n_cfg.batch_count   = pwdata[3:0];
                im2c_pkg::REG_CHANNELS: n_cfg.channel_count = pwdata[9:0];
                im2c_pkg::REG_HEIGHT:   n_cfg.image_height  = pwdata[8:0];
                im2c_pkg::REG_WIDTH:    n_cfg.image_width   = pwdata[8:0];
                im2c_pkg::REG_KERNEL:   n_cfg.kernel_shape  = pwdata[7:0];
                im2c_pkg::REG_STRIDE:   n_cfg.stride_shape  = pwdata[7:0];
                im2c_pkg::REG_PADDING:  n_cfg.padding_shape = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            im2c_pkg::REG_LAYOUT:   prdata = im2c_pkg::APB_DW'(r_cfg.layout_mode);
            im2c_pkg::REG_BATCH:    prdata = im2c_pkg::APB_DW'(r_cfg.batch_count);
            im2c_pkg::REG_CHANNELS: prdata = im2c_pkg::APB_DW'(r_cfg.channel_count);
            im2c_pkg::REG_HEIGHT:   prdata = im2c_pkg::APB_DW'(r_cfg.image_height);
            im2c_pkg::REG_WIDTH:    prdata = im2c_pkg::APB_DW'(r_cfg.image_width);
            im2c_pkg::REG_KERNEL:   prdata = im2c_pkg::APB_DW'(r_cfg.kernel_shape);
            im2c_pkg::REG_STRIDE:   prdata = im2c_pkg::APB_DW'(r_cfg.stride_shape);
            im2c_pkg::REG_PADDING:  prdata = im2c_pkg::APB_DW'(r_cfg.padding_shape);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= im2c_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### rtl/core/im2c_front.sv
// Front end of the im2col address generator: accepts input transactions
// into a short queue that decouples them from the back end. Depends on im2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module im2c_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_restart,
    output im2c_pkg::t_item o_item,
    input  logic            i_pop
);

    logic                            r_q [im2c_pkg::Q_DEPTH];
    logic [im2c_pkg::Q_PTR_W-1:0]    r_wp;
    logic [im2c_pkg::Q_PTR_W-1:0]    r_rp;
    logic [im2c_pkg::Q_CNT_W-1:0]    r_cnt;
    logic                            push;

    assign o_stall        = (r_cnt == im2c_pkg::Q_CNT_W'(im2c_pkg::Q_DEPTH));
    assign push           = i_valid & ~o_stall;
    assign o_item.valid   = (r_cnt != '0);
    assign o_item.restart = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == im2c_pkg::Q_PTR_W'(im2c_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == im2c_pkg::Q_PTR_W'(im2c_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/im2c_div.sv
// Restoring divider for output size computation, one quotient bit per cycle.
// Depends on im2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module im2c_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [im2c_pkg::SIZE_W-1:0]   i_dividend,
    input  logic [im2c_pkg::NIB_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [im2c_pkg::SIZE_W-1:0]   o_quotient
);

    logic [im2c_pkg::SIZE_W-1:0]     r_quo;
    logic [im2c_pkg::NIB_W-1:0]      r_rem;
    logic [im2c_pkg::NIB_W-1:0]      r_div;
    logic [im2c_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                            r_busy;
    logic [im2c_pkg::NIB_W:0]        rem_sh;
    logic                            ge;
    logic [im2c_pkg::NIB_W:0]        rem_nx;

    assign rem_sh     = {r_rem, r_quo[im2c_pkg::SIZE_W-1]};
    assign ge         = (rem_sh >= {1'b0, r_div});
    assign rem_nx     = ge ? rem_sh - {1'b0, r_div} : rem_sh;
    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[im2c_pkg::SIZE_W-2:0], ge};
            r_rem <= rem_nx[im2c_pkg::NIB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= im2c_pkg::DIV_CNT_W'(im2c_pkg::SIZE_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != im2c_pkg::DIV_CNT_W'(1));
        end
    end

endmodule

`default_nettype wire

### rtl/core/im2c_back.sv
// Back end of the im2col address generator: walks the column matrix, forms
// destination and source indexes and holds the result. Depends on im2c_pkg,
// im2c_div and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module im2c_back #(
    parameter int MAX_BATCH      = 8,
    parameter int MAX_CHANNELS   = 512,
    parameter int MAX_IMAGE_SIZE = 256,
    parameter int MAX_KERNEL     = 15,
    parameter int INDEX_BITS     = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  im2c_pkg::t_cfg  i_cfg,
    input  logic            i_cfg_wr,
    input  im2c_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output im2c_pkg::t_res  o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_IDX  = 5'b00100,
        S_EMIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam int SW = im2c_pkg::SIZE_W;
    localparam int NW = im2c_pkg::NIB_W;
    localparam int PW = im2c_pkg::POS_W;
    localparam int IW = im2c_pkg::IDX_W;

    t_state                          r_state, n_state;
    logic [SW-1:0]                   r_rows, n_rows, r_cols, n_cols;
    logic [SW-1:0]                   r_orp, n_orp, r_ocp, n_ocp;
    logic [NW-1:0]                   r_kc, n_kc, r_kr, n_kr, r_img, n_img;
    logic [im2c_pkg::CH_W-1:0]       r_ch, n_ch;
    logic signed [PW-1:0]            r_row_base, n_row_base, r_col_base, n_col_base;
    logic [im2c_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_done, n_done;
    logic [1:0]                      r_step, n_step;
    logic [IW-1:0]                   r_acc, n_acc;
    im2c_pkg::t_res                  r_res, n_res;

    logic [NW-1:0]                   kh, kw, sh, sw, pt, pl, pb, pr;
    logic [SW-1:0]                   tot_h, tot_w;
    logic                            sizes_ok, fits;
    logic signed [PW-1:0]            row, col;
    logic                            pad;
    logic [SW-1:0]                   mul_m, mul_a;
    logic [IW-1:0]                   mac;
    logic                            kc_end, kr_end, ch_end, img_end, orp_end, ocp_end;
    logic                            last, err;
    logic                            div_start, busy_h, busy_w;
    logic [SW-1:0]                   quo_h, quo_w;

    assign kh = i_cfg.kernel_shape[7:4];
    assign kw = i_cfg.kernel_shape[3:0];
    assign sh = i_cfg.stride_shape[7:4];
    assign sw = i_cfg.stride_shape[3:0];
    assign pt = i_cfg.padding_shape[15:12];
    assign pl = i_cfg.padding_shape[11:8];
    assign pb = i_cfg.padding_shape[7:4];
    assign pr = i_cfg.padding_shape[3:0];

    assign tot_h = SW'(i_cfg.image_height) + SW'(pt) + SW'(pb);
    assign tot_w = SW'(i_cfg.image_width) + SW'(pl) + SW'(pr);

    assign sizes_ok = (i_cfg.batch_count != '0) && (32'(i_cfg.batch_count) <= MAX_BATCH)
                   && (i_cfg.channel_count != '0)
                   && (32'(i_cfg.channel_count) <= MAX_CHANNELS)
                   && (i_cfg.image_height != '0)
                   && (32'(i_cfg.image_height) <= MAX_IMAGE_SIZE)
                   && (i_cfg.image_width != '0)
                   && (32'(i_cfg.image_width) <= MAX_IMAGE_SIZE)
                   && (kh != '0) && (32'(kh) <= MAX_KERNEL)
                   && (kw != '0) && (32'(kw) <= MAX_KERNEL)
                   && (sh != '0) && (sw != '0);
    assign fits = (tot_h >= SW'(kh)) && (tot_w >= SW'(kw));

    assign row = $signed(PW'(r_kr)) + r_row_base;
    assign col = $signed(PW'(r_kc)) + r_col_base;
    assign pad = (row < 0) || (col < 0)
              || (row >= $signed(PW'(i_cfg.image_height)))
              || (col >= $signed(PW'(i_cfg.image_width)));

    always_comb begin
        case ({i_cfg.layout_mode, r_step})
            {im2c_pkg::LAYOUT_NCHW, 2'd0}: begin
                mul_m = SW'(i_cfg.channel_count);
                mul_a = SW'(r_ch);
            end
            {im2c_pkg::LAYOUT_NCHW, 2'd1}: begin
                mul_m = SW'(i_cfg.image_height);
                mul_a = row[SW-1:0];
            end
            {im2c_pkg::LAYOUT_NCHW, 2'd2}: begin
                mul_m = SW'(i_cfg.image_width);
                mul_a = col[SW-1:0];
            end
            {~im2c_pkg::LAYOUT_NCHW, 2'd0}: begin
                mul_m = SW'(i_cfg.image_height);
                mul_a = row[SW-1:0];
            end
            {~im2c_pkg::LAYOUT_NCHW, 2'd1}: begin
                mul_m = SW'(i_cfg.image_width);
                mul_a = col[SW-1:0];
            end
            default: begin
                mul_m = SW'(i_cfg.channel_count);
                mul_a = SW'(r_ch);
            end
        endcase
    end

    assign mac = IW'(r_acc * IW'(mul_m)) + IW'(mul_a);

    assign kc_end  = (r_kc == kw - 1'b1);
    assign kr_end  = (r_kr == kh - 1'b1);
    assign ch_end  = (r_ch == i_cfg.channel_count - 1'b1);
    assign img_end = (r_img == i_cfg.batch_count - 1'b1);
    assign orp_end = (r_orp == r_rows - 1'b1);
    assign ocp_end = (r_ocp == r_cols - 1'b1);
    assign last    = kc_end && kr_end && ch_end && img_end && orp_end && ocp_end;
    assign err     = (|(r_count >> INDEX_BITS)) || (!pad && (|(r_acc >> INDEX_BITS)));

    im2c_div u_div_h (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (tot_h - SW'(kh)),
        .i_divisor  (sh),
        .o_busy     (busy_h),
        .o_quotient (quo_h)
    );

    im2c_div u_div_w (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (tot_w - SW'(kw)),
        .i_divisor  (sw),
        .o_busy     (busy_w),
        .o_quotient (quo_w)
    );

    always_comb begin
        n_state    = r_state;
        n_rows     = r_rows;
        n_cols     = r_cols;
        n_orp      = r_orp;
        n_ocp      = r_ocp;
        n_kc       = r_kc;
        n_kr       = r_kr;
        n_ch       = r_ch;
        n_img      = r_img;
        n_row_base = r_row_base;
        n_col_base = r_col_base;
        n_count    = r_count;
        n_done     = r_done;
        n_step     = r_step;
        n_acc      = r_acc;
        n_res      = r_res;
        o_pop      = 1'b0;
        div_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    o_pop = 1'b1;
                    if (i_item.restart) begin
                        n_done = 1'b1;
                        if (sizes_ok && fits) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end
                    end else if (r_done) begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_acc   = IW'(r_img);
                        n_step  = '0;
                        n_state = S_IDX;
                    end
                end
            end
            S_DIV: begin
                if (!busy_h && !busy_w) begin
                    n_rows     = quo_h + 1'b1;
                    n_cols     = quo_w + 1'b1;
                    n_orp      = '0;
                    n_ocp      = '0;
                    n_kc       = '0;
                    n_kr       = '0;
                    n_ch       = '0;
                    n_img      = '0;
                    n_row_base = $signed(PW'(0) - PW'(pt));
                    n_col_base = $signed(PW'(0) - PW'(pl));
                    n_count    = '0;
                    n_done     = 1'b0;
                    n_acc      = '0;
                    n_step     = '0;
                    n_state    = S_IDX;
                end
            end
            S_IDX: begin
                n_acc  = mac;
                n_step = r_step + 1'b1;
                if (r_step == 2'd2) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_res.valid_res    = 1'b1;
                n_res.dest_index   = r_count[IW-1:0];
                n_res.source_index = pad ? '0 : r_acc;
                n_res.is_padding   = pad;
                n_res.last_element = last;
                n_res.range_error  = err;
                n_state            = S_OUT;
                if (last) begin
                    n_done = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                    if (i_cfg.layout_mode == im2c_pkg::LAYOUT_NCHW) begin
                        if (ocp_end) begin
                            n_ocp      = '0;
                            n_col_base = $signed(PW'(0) - PW'(pl));
                            if (orp_end) begin
                                n_orp      = '0;
                                n_row_base = $signed(PW'(0) - PW'(pt));
                                if (img_end) begin
                                    n_img = '0;
                                    if (kc_end) begin
                                        n_kc = '0;
                                        if (kr_end) begin
                                            n_kr = '0;
                                            n_ch = r_ch + 1'b1;
                                        end else begin
                                            n_kr = r_kr + 1'b1;
                                        end
                                    end else begin
                                        n_kc = r_kc + 1'b1;
                                    end
                                end else begin
                                    n_img = r_img + 1'b1;
                                end
                            end else begin
                                n_orp      = r_orp + 1'b1;
                                n_row_base = r_row_base + $signed(PW'(sh));
                            end
                        end else begin
                            n_ocp      = r_ocp + 1'b1;
                            n_col_base = r_col_base + $signed(PW'(sw));
                        end
                    end else begin
                        if (kc_end) begin
                            n_kc = '0;
                            if (kr_end) begin
                                n_kr = '0;
                                if (ch_end) begin
                                    n_ch = '0;
                                    if (ocp_end) begin
                                        n_ocp      = '0;
                                        n_col_base = $signed(PW'(0) - PW'(pl));
                                        if (orp_end) begin
                                            n_orp      = '0;
                                            n_row_base = $signed(PW'(0) - PW'(pt));
                                            n_img      = r_img + 1'b1;
                                        end else begin
                                            n_orp      = r_orp + 1'b1;
                                            n_row_base = r_row_base + $signed(PW'(sh));
                                        end
                                    end else begin
                                        n_ocp      = r_ocp + 1'b1;
                                        n_col_base = r_col_base + $signed(PW'(sw));
                                    end
                                end else begin
                                    n_ch = r_ch + 1'b1;
                                end
                            end else begin
                                n_kr = r_kr + 1'b1;
                            end
                        end else begin
                            n_kc = r_kc + 1'b1;
                        end
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wr) begin
            n_done = 1'b1;
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rows     <= '0;
            r_cols     <= '0;
            r_orp      <= '0;
            r_ocp      <= '0;
            r_kc       <= '0;
            r_kr       <= '0;
            r_ch       <= '0;
            r_img      <= '0;
            r_row_base <= '0;
            r_col_base <= '0;
            r_count    <= '0;
            r_done     <= 1'b1;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_rows     <= n_rows;
            r_cols     <= n_cols;
            r_orp      <= n_orp;
            r_ocp      <= n_ocp;
            r_kc       <= n_kc;
            r_kr       <= n_kr;
            r_ch       <= n_ch;
            r_img      <= n_img;
            r_row_base <= n_row_base;
            r_col_base <= n_col_base;
            r_count    <= n_count;
            r_done     <= n_done;
            r_step     <= n_step;
        end
    end

    `ASSERT_IMPLY(a_empty_res_zero, o_valid && !o_res.valid_res, (o_res.dest_index == '0) && (o_res.source_index == '0) && !o_res.is_padding && !o_res.last_element && !o_res.range_error, "empty result carries nonzero fields")
    `ASSERT_IMPLY(a_pad_src_zero, o_valid && o_res.valid_res && o_res.is_padding, o_res.source_index == '0, "padding element with nonzero source index")
    `ASSERT_NEXT(a_last_ends_seq, (r_state == S_EMIT) && last, r_done, "sequence still running after last element")
    `ASSERT_IMPLY(a_div_idle_start, div_start, !busy_h && !busy_w, "divider restarted while busy")

endmodule

`default_nettype wire

### rtl/core/im2col_address_generator_core.sv
// im2col address generator: one column matrix element per advance transaction.
// Each transaction is popped by the back end, passes three index multiply-add steps, an emit
// state and the output state; an empty result goes straight from pop to output. A restart
// first runs the output size division. The back end takes the next transaction only after
// its output is taken. Reset: synchronous active low; no sequence runs.
// Depends on im2c_pkg, im2c_regs, im2c_front, im2c_back.
`timescale 1ns / 1ps
`default_nettype none

module im2col_address_generator_core #(
    parameter int MAX_BATCH      = 8,
    parameter int MAX_CHANNELS   = 512,
    parameter int MAX_IMAGE_SIZE = 256,
    parameter int MAX_KERNEL     = 15,
    parameter int INDEX_BITS     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [im2c_pkg::APB_AW-1:0]    paddr,
    input  logic [im2c_pkg::APB_DW-1:0]    pwdata,
    output logic [im2c_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_restart,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_valid_res,
    output logic [im2c_pkg::IDX_W-1:0]     o_dest_index,
    output logic [im2c_pkg::IDX_W-1:0]     o_source_index,
    output logic                           o_is_padding,
    output logic                           o_last_element,
    output logic                           o_range_error
);

    im2c_pkg::t_cfg  cfg;
    logic            cfg_wr;
    im2c_pkg::t_item item;
    logic            pop;
    im2c_pkg::t_res  res;

    im2c_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    im2c_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_restart (i_restart),
        .o_item    (item),
        .i_pop     (pop)
    );

    im2c_back #(
        .MAX_BATCH      (MAX_BATCH),
        .MAX_CHANNELS   (MAX_CHANNELS),
        .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE),
        .MAX_KERNEL     (MAX_KERNEL),
        .INDEX_BITS     (INDEX_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_cfg_wr (cfg_wr),
        .i_item   (item),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_res    (res)
    );

    assign o_valid_res    = res.valid_res;
    assign o_dest_index   = res.dest_index;
    assign o_source_index = res.source_index;
    assign o_is_padding   = res.is_padding;
    assign o_last_element = res.last_element;
    assign o_range_error  = res.range_error;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for im2col_address_generator_core: drives restart/advance
// transactions and APB register writes, predicts each column matrix element.
// Depends on im2c_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int      LIM_BATCH    = 8;
    localparam int      LIM_CHANNELS = 512;
    localparam int      LIM_IMAGE    = 256;
    localparam int      LIM_KERNEL   = 15;
    localparam int      INDEX_WIDTH  = 32;
    localparam longint  INDEX_LIMIT  = longint'(1) << INDEX_WIDTH;
    localparam int      ITEM_TARGET  = 1150;
    localparam int      CYCLE_LIMIT  = 400000;

    typedef enum int { CFG_TINY, CFG_LARGE, CFG_NOISE } t_cfg_kind;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [im2c_pkg::APB_AW-1:0]   paddr = '0;
    logic [im2c_pkg::APB_DW-1:0]   pwdata = '0;
    logic [im2c_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_restart = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_valid_res;
    logic [im2c_pkg::IDX_W-1:0]    o_dest_index;
    logic [im2c_pkg::IDX_W-1:0]    o_source_index;
    logic                          o_is_padding;
    logic                          o_last_element;
    logic                          o_range_error;

    im2col_address_generator_core #(
        .MAX_BATCH      (LIM_BATCH),
        .MAX_CHANNELS   (LIM_CHANNELS),
        .MAX_IMAGE_SIZE (LIM_IMAGE),
        .MAX_KERNEL     (LIM_KERNEL),
        .INDEX_BITS     (INDEX_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_valid_res    (o_valid_res),
        .o_dest_index   (o_dest_index),
        .o_source_index (o_source_index),
        .o_is_padding   (o_is_padding),
        .o_last_element (o_last_element),
        .o_range_error  (o_range_error)
    );

    // Generator model state
    im2c_pkg::t_cfg  cfg_model = im2c_pkg::CFG_RESET;
    longint          grid_rows = 0;
    longint          grid_cols = 0;
    longint          patch_idx = 0;
    longint          image_idx = 0;
    longint          row_idx = 0;
    longint          col_idx = 0;
    longint          elem_count = 0;
    bit              walk_done = 1'b1;

    bit              pending_restart[$];
    im2c_pkg::t_res  expected_elems[$];
    int              items_queued = 0;
    int              items_sent = 0;
    int              elems_seen = 0;
    int              hold_left = 0;
    int              mismatches = 0;
    int              cycle_count = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint out_extent(longint size, longint pa, longint pb,
                                          longint k, longint s);
        longint total;
        total = size + pa + pb;
        if (total < k) return 0;
        return (total - k) / s + 1;
    endfunction

    function automatic bit sizes_legal(im2c_pkg::t_cfg c);
        if (c.batch_count < 1 || c.batch_count > LIM_BATCH) return 1'b0;
        if (c.channel_count < 1 || c.channel_count > LIM_CHANNELS) return 1'b0;
        if (c.image_height < 1 || c.image_height > LIM_IMAGE) return 1'b0;
        if (c.image_width < 1 || c.image_width > LIM_IMAGE) return 1'b0;
        if (c.kernel_shape[7:4] < 1 || c.kernel_shape[7:4] > LIM_KERNEL) return 1'b0;
        if (c.kernel_shape[3:0] < 1 || c.kernel_shape[3:0] > LIM_KERNEL) return 1'b0;
        if (c.stride_shape[7:4] == 0 || c.stride_shape[3:0] == 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic longint matrix_elements(im2c_pkg::t_cfg c);
        longint rows;
        longint cols;
        if (!sizes_legal(c)) return 0;
        rows = out_extent(longint'(c.image_height), longint'(c.padding_shape[15:12]),
                          longint'(c.padding_shape[7:4]), longint'(c.kernel_shape[7:4]),
                          longint'(c.stride_shape[7:4]));
        cols = out_extent(longint'(c.image_width), longint'(c.padding_shape[11:8]),
                          longint'(c.padding_shape[3:0]), longint'(c.kernel_shape[3:0]),
                          longint'(c.stride_shape[3:0]));
        return longint'(c.channel_count) * longint'(c.kernel_shape[7:4]) *
               longint'(c.kernel_shape[3:0]) * longint'(c.batch_count) * rows * cols;
    endfunction

    // Advance the gather walk by one transaction and return the element it yields.
    function automatic im2c_pkg::t_res gather_step(bit restart);
        im2c_pkg::t_res r;
        longint  kh, kw, sh, sw, pt, pl, patches, kc, kr, ch, row, col, src;
        longint  nb, nc, nh, nw;
        bit      pad, last;
        r = '0;
        if (restart) begin
            walk_done = 1'b1;
            if (sizes_legal(cfg_model)) begin
                grid_rows = out_extent(longint'(cfg_model.image_height),
                                       longint'(cfg_model.padding_shape[15:12]),
                                       longint'(cfg_model.padding_shape[7:4]),
                                       longint'(cfg_model.kernel_shape[7:4]),
                                       longint'(cfg_model.stride_shape[7:4]));
                grid_cols = out_extent(longint'(cfg_model.image_width),
                                       longint'(cfg_model.padding_shape[11:8]),
                                       longint'(cfg_model.padding_shape[3:0]),
                                       longint'(cfg_model.kernel_shape[3:0]),
                                       longint'(cfg_model.stride_shape[3:0]));
                if (grid_rows > 0 && grid_cols > 0) begin
                    patch_idx = 0;
                    image_idx = 0;
                    row_idx = 0;
                    col_idx = 0;
                    elem_count = 0;
                    walk_done = 1'b0;
                end
            end else begin
                grid_rows = 0;
                grid_cols = 0;
            end
        end
        if (walk_done) return r;

        kh = longint'(cfg_model.kernel_shape[7:4]);
        kw = longint'(cfg_model.kernel_shape[3:0]);
        sh = longint'(cfg_model.stride_shape[7:4]);
        sw = longint'(cfg_model.stride_shape[3:0]);
        pt = longint'(cfg_model.padding_shape[15:12]);
        pl = longint'(cfg_model.padding_shape[11:8]);
        nb = longint'(cfg_model.batch_count);
        nc = longint'(cfg_model.channel_count);
        nh = longint'(cfg_model.image_height);
        nw = longint'(cfg_model.image_width);
        patches = nc * kh * kw;
        kc = patch_idx % kw;
        kr = (patch_idx / kw) % kh;
        ch = patch_idx / (kh * kw);
        row = kr + row_idx * sh - pt;
        col = kc + col_idx * sw - pl;
        pad = row < 0 || col < 0 || row >= nh || col >= nw;
        last = patch_idx == patches - 1 && image_idx == nb - 1 &&
               row_idx == grid_rows - 1 && col_idx == grid_cols - 1;
        src = 0;
        if (!pad) begin
            if (cfg_model.layout_mode == im2c_pkg::LAYOUT_NCHW)
                src = ((image_idx * nc + ch) * nh + row) * nw + col;
            else
                src = ((image_idx * nh + row) * nw + col) * nc + ch;
        end
        r.valid_res    = 1'b1;
        r.dest_index   = elem_count[im2c_pkg::IDX_W-1:0];
        r.source_index = src[im2c_pkg::IDX_W-1:0];
        r.is_padding   = pad;
        r.last_element = last;
        r.range_error  = elem_count >= INDEX_LIMIT || src >= INDEX_LIMIT;

        if (last) begin
            walk_done = 1'b1;
            return r;
        end
        elem_count++;
        if (cfg_model.layout_mode == im2c_pkg::LAYOUT_NCHW) begin
            if (++col_idx == grid_cols) begin
                col_idx = 0;
                if (++row_idx == grid_rows) begin
                    row_idx = 0;
                    if (++image_idx == nb) begin
                        image_idx = 0;
                        patch_idx++;
                    end
                end
            end
        end else begin
            if (++patch_idx == patches) begin
                patch_idx = 0;
                if (++col_idx == grid_cols) begin
                    col_idx = 0;
                    if (++row_idx == grid_rows) begin
                        row_idx = 0;
                        image_idx++;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic im2c_pkg::t_cfg random_cfg(t_cfg_kind kind);
        im2c_pkg::t_cfg c;
        c.layout_mode = 1'($urandom_range(1));
        case (kind)
            CFG_TINY: begin
                c.batch_count   = 4'($urandom_range(1, 3));
                c.channel_count = 10'($urandom_range(1, 3));
                c.image_height  = 9'($urandom_range(1, 6));
                c.image_width   = 9'($urandom_range(1, 6));
                c.kernel_shape  = {4'($urandom_range(1, 4)), 4'($urandom_range(1, 4))};
                c.stride_shape  = {4'($urandom_range(1, 3)), 4'($urandom_range(1, 3))};
                c.padding_shape = {4'($urandom_range(2)), 4'($urandom_range(2)),
                                   4'($urandom_range(2)), 4'($urandom_range(2))};
            end
            CFG_LARGE: begin
                c.batch_count   = 4'($urandom_range(1, LIM_BATCH));
                c.channel_count = 10'($urandom_range(256, LIM_CHANNELS));
                c.image_height  = 9'($urandom_range(128, LIM_IMAGE));
                c.image_width   = 9'($urandom_range(128, LIM_IMAGE));
                c.kernel_shape  = {4'($urandom_range(8, 15)), 4'($urandom_range(8, 15))};
                c.stride_shape  = {4'($urandom_range(1, 15)), 4'($urandom_range(1, 15))};
                c.padding_shape = 16'($urandom);
            end
            default: begin
                c.batch_count   = 4'($urandom);
                c.channel_count = 10'($urandom);
                c.image_height  = 9'($urandom);
                c.image_width   = 9'($urandom);
                c.kernel_shape  = 8'($urandom);
                c.stride_shape  = 8'($urandom);
                c.padding_shape = 16'($urandom);
            end
        endcase
        return c;
    endfunction

    task automatic reg_write(input logic [im2c_pkg::REG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= im2c_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            im2c_pkg::REG_LAYOUT:   cfg_model.layout_mode   = value[0];
            im2c_pkg::REG_BATCH:    cfg_model.batch_count   = value[3:0];
            im2c_pkg::REG_CHANNELS: cfg_model.channel_count = value[9:0];
            im2c_pkg::REG_HEIGHT:   cfg_model.image_height  = value[8:0];
            im2c_pkg::REG_WIDTH:    cfg_model.image_width   = value[8:0];
            im2c_pkg::REG_KERNEL:   cfg_model.kernel_shape  = value[7:0];
            im2c_pkg::REG_STRIDE:   cfg_model.stride_shape  = value[7:0];
            im2c_pkg::REG_PADDING:  cfg_model.padding_shape = value;
            default: ;
        endcase
        walk_done = 1'b1;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_restart.size() != 0 || i_in_valid || expected_elems.size() != 0);
    endtask

    task automatic apply_config(input im2c_pkg::t_cfg c);
        wait_drained();
        reg_write(im2c_pkg::REG_LAYOUT, 16'(c.layout_mode));
        reg_write(im2c_pkg::REG_BATCH, 16'(c.batch_count));
        reg_write(im2c_pkg::REG_CHANNELS, 16'(c.channel_count));
        reg_write(im2c_pkg::REG_HEIGHT, 16'(c.image_height));
        reg_write(im2c_pkg::REG_WIDTH, 16'(c.image_width));
        reg_write(im2c_pkg::REG_KERNEL, 16'(c.kernel_shape));
        reg_write(im2c_pkg::REG_STRIDE, 16'(c.stride_shape));
        reg_write(im2c_pkg::REG_PADDING, c.padding_shape);
    endtask

    task automatic queue_walk(input int count);
        for (int i = 0; i < count; i++)
            pending_restart.push_back(i == 0 || $urandom_range(99) < 3);
        items_queued += count;
    endtask

    task automatic queue_directed(input bit seq[]);
        foreach (seq[i]) pending_restart.push_back(seq[i]);
        items_queued += seq.size();
    endtask

    initial begin
        im2c_pkg::t_cfg c;
        int   pick;
        int   count;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes: advance while idle, then a restart whose output is empty.
        queue_directed('{1'b0, 1'b1, 1'b0});

        c = '{layout_mode: 1'b0, batch_count: 4'd2, channel_count: 10'd1,
              image_height: 9'd1, image_width: 9'd1, kernel_shape: 8'h11,
              stride_shape: 8'h11, padding_shape: 16'h1000};
        apply_config(c);
        queue_directed('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});

        c = '{layout_mode: 1'b1, batch_count: 4'd1, channel_count: 10'd2,
              image_height: 9'd2, image_width: 9'd2, kernel_shape: 8'h12,
              stride_shape: 8'h12, padding_shape: 16'h0001};
        apply_config(c);
        queue_directed('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});

        c = '{layout_mode: 1'b1, batch_count: 4'd8, channel_count: 10'd512,
              image_height: 9'd256, image_width: 9'd256, kernel_shape: 8'hFF,
              stride_shape: 8'hFF, padding_shape: 16'hFFFF};
        apply_config(c);
        queue_directed('{1'b1, 1'b0, 1'b0});

        // Oversized batch; the write also ends the running walk.
        c.batch_count = 4'd15;
        apply_config(c);
        queue_directed('{1'b0, 1'b1});

        while (items_queued < ITEM_TARGET) begin
            pick = int'($urandom_range(9));
            if (pick == 0) begin
                c = random_cfg(CFG_NOISE);
                count = int'($urandom_range(3, 12));
            end else if (pick == 1) begin
                c = random_cfg(CFG_LARGE);
                count = int'($urandom_range(3, 20));
            end else begin
                do c = random_cfg(CFG_TINY);
                while (matrix_elements(c) == 0 || matrix_elements(c) > 120);
                count = int'(matrix_elements(c)) + int'($urandom_range(3));
            end
            apply_config(c);
            queue_walk(count);
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        bit take_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_restart  <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_elems.push_back(gather_step(i_restart));
                items_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                take_next = pending_restart.size() != 0 &&
                            ((items_sent >= 300 && items_sent < 500) ||
                             $urandom_range(99) >= 13);
                if (take_next) begin
                    i_restart <= pending_restart.pop_front();
                end
                i_in_valid <= take_next;
            end
        end
    end

    task automatic check_field(input string name, input logic [im2c_pkg::IDX_W-1:0] want,
                               input logic [im2c_pkg::IDX_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        im2c_pkg::t_res want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_elems.size() == 0) begin
                    $error("unexpected transaction: no element pending");
                    mismatches++;
                end else begin
                    want = expected_elems.pop_front();
                    check_field("valid_res", im2c_pkg::IDX_W'(want.valid_res),
                                im2c_pkg::IDX_W'(o_valid_res));
                    check_field("dest_index", want.dest_index, o_dest_index);
                    check_field("source_index", want.source_index, o_source_index);
                    check_field("is_padding", im2c_pkg::IDX_W'(want.is_padding),
                                im2c_pkg::IDX_W'(o_is_padding));
                    check_field("last_element", im2c_pkg::IDX_W'(want.last_element),
                                im2c_pkg::IDX_W'(o_last_element));
                    check_field("range_error", im2c_pkg::IDX_W'(want.range_error),
                                im2c_pkg::IDX_W'(o_range_error));
                end
                elems_seen++;
                if (elems_seen == 900) hold_left = 160;
            end
            if (hold_left > 0) hold_left--;
            i_out_stall <= hold_left > 0 ||
                           (!(elems_seen >= 600 && elems_seen < 800) &&
                            $urandom_range(99) < 13);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
